### rtl/scpf_pkg.sv
// scpf_pkg: types and constants shared by the sensor command packet framer
// no dependencies
`default_nettype none

package scpf_pkg;

    localparam int ARG_FIELDS = 4;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 4;

    localparam logic [7:0]  START_HI     = 8'hEF;
    localparam logic [7:0]  START_LO     = 8'h01;
    localparam logic [7:0]  PKT_TYPE_CMD = 8'h01;
    localparam logic [31:0] ADDR_RESET   = 32'hFFFF_FFFF;

    // byte positions inside a command packet
    localparam logic [IDX_W-1:0] IDX_START_HI = 4'd0;
    localparam logic [IDX_W-1:0] IDX_START_LO = 4'd1;
    localparam logic [IDX_W-1:0] IDX_ADDR3    = 4'd2;
    localparam logic [IDX_W-1:0] IDX_ADDR2    = 4'd3;
    localparam logic [IDX_W-1:0] IDX_ADDR1    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_ADDR0    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_TYPE     = 4'd6;
    localparam logic [IDX_W-1:0] IDX_LEN_HI   = 4'd7;
    localparam logic [IDX_W-1:0] IDX_LEN_LO   = 4'd8;
    localparam logic [IDX_W-1:0] IDX_CMD      = 4'd9;
    localparam logic [IDX_W-1:0] IDX_ARGS     = 4'd10;

    typedef struct packed {
        logic [7:0]                      command;
        logic [CNT_W-1:0]                count;
        logic [ARG_FIELDS-1:0][7:0]      args;
        logic [15:0]                     length;
        logic [15:0]                     checksum;
    } scpf_req_t;

    typedef struct packed {
        logic             load;
        logic             last;
        logic [IDX_W-1:0] index;
    } scpf_seq_status_t;

endpackage

`default_nettype wire

### rtl/sensor_command_packet_framer_core.sv
// sensor_command_packet_framer_core: top level of the command packet framer
// depends on scpf_pkg, scpf_req, scpf_seq
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata: command, arg_count, arg0..arg3
//  m_*       out  m_tvalid/m_tready   m_tdata: tx_byte; m_tlast: last_byte
//  cfg_*     in   cfg_wr_en           cfg_wr_data: device_address
//
// one packet of 12 + arg_count bytes (at most 16 with the count saturated) leaves at one
// beat per cycle while m_tready is high, built by the byte sequencer driving the output register
// the next request is taken in the cycle the last byte of the current one loads
// m_tready low while m_tvalid is high holds the output register and the sequencer index in place
// aresetn low clears valids and sets device_address to all ones
`default_nettype none

module sensor_command_packet_framer_core
    import scpf_pkg::*;
#(
    parameter int MAX_ARGS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // command, arg_count, arg0, arg1, arg2, arg3, zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // tx_byte
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);

    logic [31:0]      addr_reg;
    logic             req_valid;
    scpf_req_t        req;
    scpf_seq_status_t seq_status;
    logic             consume;
    logic             in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= ADDR_RESET;
        end else if (cfg_wr_en) begin
            addr_reg <= cfg_wr_data;
        end
    end

    assign consume  = seq_status.load && seq_status.last;
    assign s_tready = !req_valid || consume;
    assign in_take  = s_tvalid && s_tready;

    scpf_req #(
        .MAX_ARGS(MAX_ARGS)
    ) u_req (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (in_take),
        .in_data  (s_tdata),
        .consume  (consume),
        .req_valid(req_valid),
        .req      (req)
    );

    scpf_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (req_valid),
        .req           (req),
        .device_address(addr_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_byte      (m_tdata),
        .out_last      (m_tlast),
        .status        (seq_status)
    );

    a_take_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && req_valid) |-> (seq_status.load && seq_status.last))
        else $error("request taken while a packet is still in progress");

    a_idle_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !req_valid |-> (seq_status.index == IDX_START_HI))
        else $error("sequencer index not at packet start while idle");

    a_reset_clears_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

### rtl/scpf_req.sv
// scpf_req: request holding register, count saturation, length and checksum
// depends on scpf_pkg
`default_nettype none

module scpf_req
    import scpf_pkg::*;
#(
    parameter int MAX_ARGS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_take,
    input  wire logic [47:0] in_data,
    input  wire logic        consume,
    output logic             req_valid,
    output scpf_req_t        req
);

    localparam int LIMIT = (MAX_ARGS < ARG_FIELDS) ? MAX_ARGS : ARG_FIELDS;
    localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LIMIT);

    logic      valid_reg, valid_next;
    scpf_req_t req_reg, req_next;

    logic [CNT_W-1:0]           cnt_raw, cnt_sat;
    logic [ARG_FIELDS-1:0][7:0] args_in;
    logic [15:0]                len;
    logic [15:0]                sum;

    always_comb begin
        cnt_raw = in_data[10:8];
        cnt_sat = (cnt_raw > LIMIT_CNT) ? LIMIT_CNT : cnt_raw;
        for (int i = 0; i < ARG_FIELDS; i++) begin
            args_in[i] = in_data[11 + 8*i +: 8];
        end
        len = 16'd3 + 16'(cnt_sat);
        sum = 16'(PKT_TYPE_CMD) + 16'(len[15:8]) + 16'(len[7:0]) + 16'(in_data[7:0]);
        for (int i = 0; i < ARG_FIELDS; i++) begin
            if (CNT_W'(i) < cnt_sat) begin
                sum = sum + 16'(args_in[i]);
            end
        end

        req_next.command  = in_data[7:0];
        req_next.count    = cnt_sat;
        req_next.args     = args_in;
        req_next.length   = len;
        req_next.checksum = sum;

        valid_next = valid_reg;
        if (consume) begin
            valid_next = 1'b0;
        end
        if (in_take) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_take) begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

### rtl/scpf_seq.sv
// scpf_seq: packet byte sequencer and output register
// depends on scpf_pkg
`default_nettype none

module scpf_seq
    import scpf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        req_valid,
    input  wire scpf_req_t   req,
    input  wire logic [31:0] device_address,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output scpf_seq_status_t status
);

    logic [IDX_W-1:0] index_reg, index_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;

    logic             load;
    logic             is_last;
    logic [IDX_W-1:0] arg_k;
    logic [IDX_W-1:0] last_idx;
    logic [7:0]       sel_byte;

    always_comb begin
        load     = req_valid && (!valid_reg || out_ready);
        arg_k    = index_reg - IDX_ARGS;
        last_idx = IDX_ARGS + IDX_W'(req.count) + 4'd1;
        is_last  = (index_reg == last_idx);

        case (index_reg)
            IDX_START_HI: sel_byte = START_HI;
            IDX_START_LO: sel_byte = START_LO;
            IDX_ADDR3:    sel_byte = device_address[31:24];
            IDX_ADDR2:    sel_byte = device_address[23:16];
            IDX_ADDR1:    sel_byte = device_address[15:8];
            IDX_ADDR0:    sel_byte = device_address[7:0];
            IDX_TYPE:     sel_byte = PKT_TYPE_CMD;
            IDX_LEN_HI:   sel_byte = req.length[15:8];
            IDX_LEN_LO:   sel_byte = req.length[7:0];
            IDX_CMD:      sel_byte = req.command;
            default: begin
                if (arg_k < IDX_W'(req.count)) begin
                    sel_byte = req.args[arg_k[1:0]];
                end else if (arg_k == IDX_W'(req.count)) begin
                    sel_byte = req.checksum[15:8];
                end else begin
                    sel_byte = req.checksum[7:0];
                end
            end
        endcase

        index_next = index_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            last_next  = is_last;
            index_next = is_last ? IDX_START_HI : index_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= IDX_START_HI;
            valid_reg <= 1'b0;
        end else begin
            index_reg <= index_next;
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign status.load  = load;
    assign status.last  = is_last;
    assign status.index = index_reg;

endmodule

`default_nettype wire

### bench/packet_frame_checker.sv
`timescale 1ns / 100ps
// packet_frame_checker: predicts the command packet bytes of every accepted request beat
// and compares them, in order, with the output beats; depends on scpf_pkg
module packet_frame_checker
    import scpf_pkg::*;
#(
    parameter int MAX_ARGS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // command, arg_count, arg0, arg1, arg2, arg3, zero fill
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // tx_byte
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output int          fail_count,
    output int          bytes_pending,
    output int          requests_seen,
    output int          bytes_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } pkt_byte_t;

    pkt_byte_t   expected_bytes[$];
    logic [31:0] device_address;

    function automatic void push_byte(input logic [7:0] data, input logic last);
        pkt_byte_t b;
        b.data = data;
        b.last = last;
        expected_bytes.push_back(b);
    endfunction

    function automatic void frame_packet(input logic [47:0] beat);
        logic [7:0]       command;
        logic [CNT_W-1:0] count;
        logic [7:0]       arg;
        logic [15:0]      length;
        logic [15:0]      checksum;
        int               limit;
        command = beat[7:0];
        count   = beat[10:8];
        limit   = (MAX_ARGS < ARG_FIELDS) ? MAX_ARGS : ARG_FIELDS;
        // oversized counts saturate
        if (int'(count) > limit)
            count = CNT_W'(limit);
        length   = 16'(count) + 16'd3;
        checksum = 16'(PKT_TYPE_CMD) + 16'(length[15:8]) + 16'(length[7:0]) + 16'(command);
        push_byte(START_HI, 1'b0);
        push_byte(START_LO, 1'b0);
        push_byte(device_address[31:24], 1'b0);
        push_byte(device_address[23:16], 1'b0);
        push_byte(device_address[15:8], 1'b0);
        push_byte(device_address[7:0], 1'b0);
        push_byte(PKT_TYPE_CMD, 1'b0);
        push_byte(length[15:8], 1'b0);
        push_byte(length[7:0], 1'b0);
        push_byte(command, 1'b0);
        for (int i = 0; i < int'(count); i++) begin
            arg      = beat[11 + 8 * i +: 8];
            checksum = checksum + 16'(arg);
            push_byte(arg, 1'b0);
        end
        push_byte(checksum[15:8], 1'b0);
        push_byte(checksum[7:0], 1'b1);
    endfunction

    initial begin
        fail_count    = 0;
        bytes_pending = 0;
        requests_seen = 0;
        bytes_checked = 0;
        device_address = ADDR_RESET;
    end

    always @(posedge aclk) begin
        pkt_byte_t want;
        if (!aresetn) begin
            device_address = ADDR_RESET;
            expected_bytes.delete();
        end else begin
            if (cfg_wr_en)
                device_address = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                frame_packet(s_tdata);
                requests_seen++;
            end
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (expected_bytes.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected beat: expected none, actual data %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data) begin
                        fail_count++;
                        $display("%0t tx_byte mismatch: expected %h, actual %h",
                                 $time, want.data, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        fail_count++;
                        $display("%0t last_byte mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
        end
        bytes_pending = expected_bytes.size();
    end

endmodule

### bench/tb_sensor_command_packet_framer_core.sv
`timescale 1ns / 100ps
// tb_sensor_command_packet_framer_core: request stimulus, receiver stalls and verdict
// for the command packet framer; depends on scpf_pkg, packet_frame_checker and the rtl
module tb_sensor_command_packet_framer_core;
    import scpf_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 110;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // command, arg_count, arg0, arg1, arg2, arg3, zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // tx_byte
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    int fail_count;
    int bytes_pending;
    int requests_seen;
    int bytes_checked;
    int send_idle;
    int recv_stall;
    int hold_cycles;
    int cycle_count;
    int address_writes;

    sensor_command_packet_framer_core #(.MAX_ARGS(4)) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    packet_frame_checker #(.MAX_ARGS(4)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .bytes_pending(bytes_pending),
        .requests_seen(requests_seen),
        .bytes_checked(bytes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: a long hold-off while hold_cycles is set, random stalls otherwise
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    task automatic send_request(input logic [7:0] cmd, input logic [2:0] cnt,
                                input logic [31:0] args);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 48'({$urandom, $urandom});
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, args[31:24], args[23:16], args[15:8], args[7:0], cnt, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random_request();
        logic [2:0] cnt;
        cnt = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
        send_request(8'($urandom_range(255)), cnt, $urandom);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (bytes_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_address(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        address_writes++;
    endtask

    initial begin
        int          idle_by_phase[4];
        int          stall_by_phase[4];
        logic [31:0] addr_by_phase[4];
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        send_idle      = 0;
        recv_stall     = 0;
        hold_cycles    = 0;
        address_writes = 0;
        idle_by_phase  = '{0, 66, 0, 35};
        stall_by_phase = '{0, 0, 66, 35};
        addr_by_phase  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: every count incl. oversized, extreme commands and arguments
        for (int c = 0; c < 8; c++) begin
            send_request(8'h00, 3'(c), 32'h0000_0000);
            send_request(8'hFF, 3'(c), 32'hFFFF_FFFF);
        end
        send_request(8'hA5, 3'd4, 32'hCC33_AA55);
        send_request(8'h5A, 3'd4, 32'h33CC_55AA);
        send_request(8'h3C, 3'd2, 32'hFFFF_1234);
        send_request(8'hC3, 3'd1, 32'hDEAD_BE80);

        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_address(addr_by_phase[p]);
            send_idle  = idle_by_phase[p];
            recv_stall = stall_by_phase[p];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == 10)
                    hold_cycles = 300;
                if (p == 1 && i == 55)
                    wait_drained();
                send_random_request();
            end
        end

        wait_drained();
        write_address(32'h1234_5678);
        send_idle  = 20;
        recv_stall = 20;
        for (int i = 0; i < 10; i++)
            send_random_request();

        wait_drained();
        $display("covered %0d requests, %0d packet beats, %0d address settings",
                 requests_seen, bytes_checked, address_writes);
        $display("handshake phases: free flow, sender gaps, receiver stalls, both, long hold-off");
        if (fail_count == 0 && bytes_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/scpf_pkg.sv
rtl/scpf_req.sv
rtl/scpf_seq.sv
rtl/sensor_command_packet_framer_core.sv
bench/packet_frame_checker.sv
bench/tb_sensor_command_packet_framer_core.sv
